// ===== sv/npag_pkg.sv =====
// Shared types, widths and register codes for the N-d axis permutation
// address generator. No dependencies; every other file imports this package.
package npag_pkg;

  localparam int MAX_DIMS   = 4;
  localparam int LEN_BITS   = 12;
  localparam int LEN_W      = LEN_BITS + 1;           // lengths 1 .. 2^LEN_BITS
  localparam int LEN_CAP    = 1 << LEN_BITS;
  localparam int AXIS_W     = 2;
  localparam int ORDER_W    = 8;
  localparam int DIMS_W     = 3;
  localparam int BYTES_W    = 4;
  localparam int MAX_BYTES  = 8;
  localparam int IDX_W      = 48;
  localparam int OFF_W      = 51;
  localparam int P23_W      = 2 * LEN_BITS + 1;       // product of two lengths
  localparam int STRIDE_W   = 3 * LEN_BITS + 1;       // product of three lengths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = ((2 * OFF_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - 2 * OFF_W;

  // Cycles the stride pipeline needs after a register changes.
  localparam int SETTLE_CYCLES = 6;
  localparam int SETTLE_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_DIMS   = 3'd0,
    REG_LEN_DIM0   = 3'd1,
    REG_LEN_DIM1   = 3'd2,
    REG_LEN_DIM2   = 3'd3,
    REG_LEN_DIM3   = 3'd4,
    REG_AXIS_ORDER = 3'd5,
    REG_ELEM_BYTES = 3'd6
  } cfg_reg_t;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [IDX_W-1:0] idx_t;

  // Everything a new sequence latches when it starts.
  typedef struct packed {
    len_t [MAX_DIMS-1:0] new_len;
    idx_t [MAX_DIMS-1:0] delta;     // source index step when that digit increments
    logic [BYTES_W-1:0]  bytes;
    logic                invalid;
    logic                all_last;  // the first element is also the last one
  } run_setup_t;

  typedef struct packed {
    idx_t               src_idx;
    idx_t               dst_idx;
    logic [BYTES_W-1:0] bytes;
    logic               last;
    logic               invalid;
  } elem_res_t;

  typedef struct packed {
    logic valid;
    logic pending;
  } walk_stat_t;

endpackage

// ===== sv/npag_setup.sv =====
// Configuration registers and the stride precompute pipeline.
// Depends on npag_pkg.
module npag_setup import npag_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output run_setup_t            setup,
  output logic                  settled
);

  logic [DIMS_W-1:0]  num_dims_r;
  len_t               len_r [MAX_DIMS];
  logic [ORDER_W-1:0] order_r;
  logic [BYTES_W-1:0] ebytes_r;
  logic [SETTLE_W-1:0] settle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r <= DIMS_W'(1);
      for (int k = 0; k < MAX_DIMS; k++) len_r[k] <= LEN_W'(1);
      order_r    <= ORDER_W'(228);
      ebytes_r   <= BYTES_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NUM_DIMS:   num_dims_r <= cfg_wdata[DIMS_W-1:0];
        REG_LEN_DIM0:   len_r[0]   <= cfg_wdata[LEN_W-1:0];
        REG_LEN_DIM1:   len_r[1]   <= cfg_wdata[LEN_W-1:0];
        REG_LEN_DIM2:   len_r[2]   <= cfg_wdata[LEN_W-1:0];
        REG_LEN_DIM3:   len_r[3]   <= cfg_wdata[LEN_W-1:0];
        REG_AXIS_ORDER: order_r    <= cfg_wdata[ORDER_W-1:0];
        REG_ELEM_BYTES: ebytes_r   <= cfg_wdata[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_W'(SETTLE_CYCLES);
    end else if (cfg_wr_en) begin
      settle_r <= SETTLE_W'(SETTLE_CYCLES);
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  assign settled = (settle_r == '0);

  // Stage 1: clamp the registers, map lengths into new order, check the order.
  logic [DIMS_W-1:0]  rd;
  len_t               lclamp [MAX_DIMS];
  len_t               e_nxt [MAX_DIMS];
  len_t               nl_nxt [MAX_DIMS];
  logic [AXIS_W-1:0]  ord_nxt [MAX_DIMS];
  logic               inv_nxt;
  logic               all_one_nxt;
  logic [BYTES_W-1:0] bytes_nxt;

  always_comb begin
    rd = num_dims_r;
    if (rd == '0) rd = DIMS_W'(1);
    if (rd > DIMS_W'(MAX_DIMS)) rd = DIMS_W'(MAX_DIMS);
    bytes_nxt = ebytes_r;
    if (bytes_nxt == '0) bytes_nxt = BYTES_W'(1);
    if (bytes_nxt > BYTES_W'(MAX_BYTES)) bytes_nxt = BYTES_W'(MAX_BYTES);
    inv_nxt     = 1'b0;
    all_one_nxt = 1'b1;
    for (int k = 0; k < MAX_DIMS; k++) begin
      lclamp[k] = len_r[k];
      if (lclamp[k] == '0) lclamp[k] = LEN_W'(1);
      if (lclamp[k] > LEN_W'(LEN_CAP)) lclamp[k] = LEN_W'(LEN_CAP);
      e_nxt[k]   = (DIMS_W'(k) < rd) ? lclamp[k] : LEN_W'(1);
      ord_nxt[k] = order_r[AXIS_W*k +: AXIS_W];
    end
    for (int i = 0; i < MAX_DIMS; i++) begin
      nl_nxt[i] = (DIMS_W'(i) < rd) ? lclamp[ord_nxt[i]] : LEN_W'(1);
      if (nl_nxt[i] != LEN_W'(1)) all_one_nxt = 1'b0;
      if (DIMS_W'(i) < rd) begin
        if (DIMS_W'(ord_nxt[i]) >= rd) inv_nxt = 1'b1;
        for (int j = 0; j < i; j++) begin
          if (ord_nxt[j] == ord_nxt[i]) inv_nxt = 1'b1;
        end
      end
    end
  end

  len_t               s1_e_r [MAX_DIMS];
  len_t               s1_nl_r [MAX_DIMS];
  logic [AXIS_W-1:0]  s1_ord_r [MAX_DIMS];
  logic               s1_inv_r;
  logic               s1_all_one_r;
  logic [BYTES_W-1:0] s1_bytes_r;

  // Stages 2 and 3: suffix products of the old lengths.
  logic [2*LEN_W-1:0]     prod23;
  logic [LEN_W+P23_W-1:0] prod123;
  logic [P23_W-1:0]       s2_p23_r;
  logic [STRIDE_W-1:0]    s3_p123_r;

  assign prod23  = (2*LEN_W)'(s1_e_r[2]) * (2*LEN_W)'(s1_e_r[3]);
  assign prod123 = (LEN_W+P23_W)'(s1_e_r[1]) * (LEN_W+P23_W)'(s2_p23_r);

  // Stage 4: old stride per new axis and the span of each digit.
  logic [STRIDE_W-1:0]          pv [MAX_DIMS];
  logic [STRIDE_W-1:0]          stride_nxt [MAX_DIMS];
  logic [LEN_W-1:0]             nlm1 [MAX_DIMS];
  logic [LEN_BITS+STRIDE_W-1:0] span [MAX_DIMS];

  always_comb begin
    pv[0] = s3_p123_r;
    pv[1] = STRIDE_W'(s2_p23_r);
    pv[2] = STRIDE_W'(s1_e_r[3]);
    pv[3] = STRIDE_W'(1);
    for (int i = 0; i < MAX_DIMS; i++) begin
      stride_nxt[i] = pv[s1_ord_r[i]];
      nlm1[i]       = s1_nl_r[i] - LEN_W'(1);
      span[i]       = (LEN_BITS+STRIDE_W)'(nlm1[i][LEN_BITS-1:0])
                    * (LEN_BITS+STRIDE_W)'(stride_nxt[i]);
    end
  end

  logic [STRIDE_W-1:0] s4_stride_r [MAX_DIMS];
  idx_t                s4_span_r [MAX_DIMS];
  idx_t                s5_suf_r [MAX_DIMS];
  idx_t                s6_delta_r [MAX_DIMS];

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_DIMS; k++) begin
      s1_e_r[k]      <= e_nxt[k];
      s1_nl_r[k]     <= nl_nxt[k];
      s1_ord_r[k]    <= ord_nxt[k];
      s4_stride_r[k] <= stride_nxt[k];
      s4_span_r[k]   <= span[k][IDX_W-1:0];
      s6_delta_r[k]  <= IDX_W'(s4_stride_r[k]) - s5_suf_r[k];
    end
    s1_inv_r     <= inv_nxt;
    s1_all_one_r <= all_one_nxt;
    s1_bytes_r   <= bytes_nxt;
    s2_p23_r     <= prod23[P23_W-1:0];
    s3_p123_r    <= prod123[STRIDE_W-1:0];
    // Stage 5: what the inner digits give back when they wrap to zero.
    s5_suf_r[3]  <= '0;
    s5_suf_r[2]  <= s4_span_r[3];
    s5_suf_r[1]  <= s4_span_r[2] + s4_span_r[3];
    s5_suf_r[0]  <= s4_span_r[1] + s4_span_r[2] + s4_span_r[3];
  end

  always_comb begin
    for (int i = 0; i < MAX_DIMS; i++) begin
      setup.new_len[i] = s1_nl_r[i];
      setup.delta[i]   = s6_delta_r[i];
    end
    setup.bytes    = s1_bytes_r;
    setup.invalid  = s1_inv_r;
    setup.all_last = s1_all_one_r;
  end

endmodule

// ===== sv/npag_walker.sv =====
// Mixed-radix walker: holds the running sequence and the element indices.
// Depends on npag_pkg.
module npag_walker import npag_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       restart,
  input  run_setup_t setup,
  input  logic       settled,
  input  logic       take_ready,
  output logic       in_ready,
  output elem_res_t  res,
  output walk_stat_t stat
);

  logic [LEN_BITS-1:0] cnt_r [MAX_DIMS];
  len_t                nl_r [MAX_DIMS];
  idx_t                delta_r [MAX_DIMS];
  idx_t                src_r;
  idx_t                dst_r;
  logic [BYTES_W-1:0]  bytes_r;
  logic                last_r;
  logic                inv_r;
  logic                pend_r;
  logic                valid_r;

  logic                accept;
  logic                start;
  logic [LEN_BITS-1:0] cnt_adv [MAX_DIMS];
  idx_t                delta_pick;
  logic                last_adv;
  logic                last_nxt;

  // Ripple the carry from the innermost digit outward.
  always_comb begin
    logic carry;
    logic wrap;
    carry      = 1'b1;
    delta_pick = '0;
    last_adv   = 1'b1;
    for (int i = MAX_DIMS - 1; i >= 0; i--) begin
      wrap       = ((LEN_W'(cnt_r[i]) + LEN_W'(1)) == nl_r[i]);
      cnt_adv[i] = cnt_r[i];
      if (carry) begin
        cnt_adv[i] = wrap ? '0 : cnt_r[i] + 1'b1;
        if (!wrap) delta_pick = delta_r[i];
      end
      carry = carry & wrap;
      if ((LEN_W'(cnt_adv[i]) + LEN_W'(1)) != nl_r[i]) last_adv = 1'b0;
    end
  end

  assign in_ready = settled && (!valid_r || take_ready);
  assign accept   = in_valid && in_ready;
  assign start    = restart || pend_r;
  assign last_nxt = start ? setup.all_last : last_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b1;
    end else begin
      valid_r <= accept || (valid_r && !take_ready);
      if (accept) pend_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= last_nxt;
      if (start) begin
        for (int k = 0; k < MAX_DIMS; k++) begin
          cnt_r[k]   <= '0;
          nl_r[k]    <= setup.new_len[k];
          delta_r[k] <= setup.delta[k];
        end
        src_r   <= '0;
        dst_r   <= '0;
        bytes_r <= setup.bytes;
        inv_r   <= setup.invalid;
      end else begin
        for (int k = 0; k < MAX_DIMS; k++) cnt_r[k] <= cnt_adv[k];
        src_r <= src_r + delta_pick;
        dst_r <= dst_r + 1'b1;
      end
    end
  end

  assign res.src_idx  = src_r;
  assign res.dst_idx  = dst_r;
  assign res.bytes    = bytes_r;
  assign res.last     = last_r;
  assign res.invalid  = inv_r;
  assign stat.valid   = valid_r;
  assign stat.pending = pend_r;

endmodule

// ===== sv/npag_out_stage.sv =====
// Output register: scales element indices to byte offsets and drives the
// result stream. Depends on npag_pkg.
module npag_out_stage import npag_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  elem_res_t             res,
  input  logic                  res_valid,
  output logic                  can_take,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output logic                  out_tuser
);

  logic                     bv_r;
  logic [OFF_W-1:0]         src_off_r;
  logic [OFF_W-1:0]         dst_off_r;
  logic                     last_r;
  logic                     inv_r;
  logic                     take;
  logic [IDX_W+BYTES_W-1:0] src_prod;
  logic [IDX_W+BYTES_W-1:0] dst_prod;

  assign can_take = !bv_r || out_tready;
  assign take     = res_valid && can_take;
  assign src_prod = (IDX_W+BYTES_W)'(res.src_idx) * (IDX_W+BYTES_W)'(res.bytes);
  assign dst_prod = (IDX_W+BYTES_W)'(res.dst_idx) * (IDX_W+BYTES_W)'(res.bytes);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= 1'b0;
    end else begin
      bv_r <= take || (bv_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      src_off_r <= src_prod[OFF_W-1:0];
      dst_off_r <= dst_prod[OFF_W-1:0];
      last_r    <= res.last;
      inv_r     <= res.invalid;
    end
  end

  assign out_tvalid = bv_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, dst_off_r, src_off_r};
  assign out_tlast  = last_r;
  assign out_tuser  = inv_r;

endmodule

// ===== sv/nd_axis_permute_address_gen.sv =====
// Top level of the N-d axis permutation address generator: one source and
// destination byte offset pair per input transaction, walked in new axis order.
// Depends on npag_pkg, npag_setup, npag_walker and npag_out_stage.
// Each result is registered in the walker and then in the output stage.
// Throughput: one transaction per cycle unless out_tready or settling holds it.
// After reset and after every configuration write, in_tready stays low while
// the stride precompute pipeline settles on the new registers.
// Reset (rst_n, synchronous, active low) loads the register defaults and makes
// the first accepted transaction start a new sequence.
module nd_axis_permute_address_gen import npag_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream. tdata fields from bit 0 up: restart (1), zero fill.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Result stream. tdata fields from bit 0 up: src_byte_offset (51),
  // dst_byte_offset (51), zero fill. tuser fields: order_invalid (1).
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output logic                  out_tuser,
  // Configuration write port.
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  run_setup_t setup;
  logic       settled;
  elem_res_t  res;
  walk_stat_t stat;
  logic       can_take;

  // The setup block keeps the registers and continuously derives the per-axis
  // lengths, strides and source steps that a sequence latches when it starts.
  npag_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .setup     (setup),
    .settled   (settled)
  );

  // The walker advances the mixed-radix counter once per transaction. The
  // source index moves by the precomputed step of the digit that increments,
  // so no multiply sits in the per-element path; the destination index is
  // simply the element count.
  npag_walker u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .restart    (in_tdata[0]),
    .setup      (setup),
    .settled    (settled),
    .take_ready (can_take),
    .in_ready   (in_tready),
    .res        (res),
    .stat       (stat)
  );

  // The output stage scales the indices by the element size and holds the
  // result until the downstream side takes it; the walker stalls while it is not taken.
  npag_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .res_valid  (stat.valid),
    .can_take   (can_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // A register change must hold off new input until the strides have settled.
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !in_tready)
    else $error("input accepted right after a configuration write");

  // A restart transaction begins at element zero in both layouts.
  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tdata[0]) |=>
      (res.src_idx == '0 && res.dst_idx == '0))
    else $error("restart did not clear the element indices");

  // An advance inside a sequence moves the destination index by one element.
  a_dst_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tdata[0] && !stat.pending) |=>
      (res.dst_idx == $past(res.dst_idx) + 1'b1))
    else $error("destination index did not step by one");

  // After each transaction the pending-start flag agrees with the last mark.
  a_last_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (stat.pending == res.last))
    else $error("last mark and sequence restart disagree");

endmodule
